@@ design/scs_pkg.sv @@
// Shared constants, types and helpers for the scan cluster segmenter.
// No dependencies; every other file but scs_if.sv imports this package.
package scs_pkg;

    localparam int MAX_POINTS_DEF  = 4096;
    localparam int COORD_WIDTH_DEF = 16;

    // Configuration register widths and codes
    localparam int GAP_W     = 15;
    localparam int LEN_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DW    = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 2'd2;

    localparam logic [GAP_W-1:0] GAP_RESET = 15'd100;
    localparam logic [LEN_W-1:0] LEN_MAX   = 24'hFF_FFFF;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Saturating add of two path lengths
    function automatic logic [LEN_W-1:0] len_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

endpackage

@@ design/scs_if.sv @@
// Valid/ready channel interfaces: scan points in, cluster reports out.
// Depends on nothing.
interface scs_point_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic                          scan_last;

    modport source (output valid, point_x, point_y, scan_last, input ready);
    modport sink   (input valid, point_x, point_y, scan_last, output ready);
endinterface

interface scs_cluster_if #(parameter int COORD_WIDTH = 16, parameter int CNT_W = 13,
                           parameter int LEN_W = 24);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] centroid_x;
    logic signed [COORD_WIDTH-1:0] centroid_y;
    logic        [LEN_W-1:0]       path_length;
    logic        [CNT_W-1:0]       point_count;
    logic                          length_ok;
    logic                          scan_done;

    modport source (output valid, centroid_x, centroid_y, path_length, point_count,
                    length_ok, scan_done, input ready);
    modport sink   (input valid, centroid_x, centroid_y, path_length, point_count,
                    length_ok, scan_done, output ready);
endinterface

@@ design/scan_cluster_segmenter_core.sv @@
// Top level of the scan cluster segmenter: configuration registers, front,
// report queue and back. Depends on scs_pkg, scs_if and the scs_* modules.
//
//  channel   dir  handshake        payload
//  i_pt      in   valid/ready      point_x, point_y, scan_last
//  o_cl      out  valid/ready      centroid_x/y, path_length, point_count,
//                                  length_ok, scan_done
//  i_cfg_*   in   write enable     cluster gap, length window low and high
//
// A point that neither joins a cluster nor ends the scan runs the squaring
// and classify states, plus a push state when it closes a cluster after the
// first; one that joins also runs the one-bit-per-cycle square root, and at
// scan end the closing segment may add another square root.
// Each report then passes through the back divider.
// Synchronous active-low reset; no clearing pass. A full report queue stalls
// the front; a stalled output register stalls the back, then the front too.
module scan_cluster_segmenter_core import scs_pkg::*; #(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0]    i_cfg_wdata,
    scs_point_if.sink            i_pt,
    scs_cluster_if.source        o_cl
);
    localparam int CNTW = $clog2(MAX_POINTS) + 1;
    localparam int SW   = COORD_WIDTH + $clog2(MAX_POINTS);
    localparam int EW   = 2 * (SW + 1) + (CNTW + 1) + LEN_W + 1;

    logic [GAP_W-1:0]   r_gap;
    logic [2*GAP_W-1:0] r_gap2;
    logic [LEN_W-1:0]   r_min_len, r_max_len;

    // Configuration writes; squared gap follows in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap     <= GAP_RESET;
            r_gap2    <= (2*GAP_W)'(GAP_RESET) * (2*GAP_W)'(GAP_RESET);
            r_min_len <= '0;
            r_max_len <= LEN_MAX;
        end else begin
            r_gap2 <= (2*GAP_W)'(r_gap) * (2*GAP_W)'(r_gap);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GAP: r_gap     <= i_cfg_wdata[GAP_W-1:0];
                    CFG_MIN: r_min_len <= i_cfg_wdata[LEN_W-1:0];
                    CFG_MAX: r_max_len <= i_cfg_wdata[LEN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    logic          push, pop;
    logic [EW-1:0] push_data, pop_data;
    t_q_stat       q_stat;

    scs_front #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_pt     (i_pt),
        .i_gap2   (r_gap2),
        .o_push   (push),
        .o_entry  (push_data),
        .i_q_stat (q_stat)
    );

    scs_fifo #(.WIDTH(EW), .DEPTH(4)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (pop_data),
        .o_stat  (q_stat)
    );

    scs_back #(.MAX_POINTS(MAX_POINTS), .COORD_WIDTH(COORD_WIDTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_entry   (pop_data),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .i_min_len (r_min_len),
        .i_max_len (r_max_len),
        .o_cl      (o_cl)
    );
endmodule

@@ design/scs_fifo.sv @@
// Short queue of cluster reports between the front and back halves.
// Depends on scs_pkg for the status struct.
module scs_fifo import scs_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
endmodule

@@ design/scs_front.sv @@
// Front half: takes points, measures gaps, builds clusters, queues reports.
// Depends on scs_pkg and the point channel interface.
module scs_front import scs_pkg::*; #(
    parameter  int MAX_POINTS  = MAX_POINTS_DEF,
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int CNTW = $clog2(MAX_POINTS) + 1,
    localparam int SW   = COORD_WIDTH + $clog2(MAX_POINTS),
    localparam int EW   = 2 * (SW + 1) + (CNTW + 1) + LEN_W + 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scs_point_if.sink          i_pt,
    input  logic [2*GAP_W-1:0] i_gap2,
    output logic               o_push,
    output logic [EW-1:0]      o_entry,
    input  t_q_stat            i_q_stat
);
    localparam int CW   = COORD_WIDTH;
    localparam int DXW  = CW + 1;
    localparam int D2W  = 2 * CW + 1;
    localparam int SQW  = CW + 1;
    localparam int CMPW = (D2W > 2 * GAP_W) ? D2W : 2 * GAP_W;
    localparam int ADDW = ((LEN_W > SQW) ? LEN_W : SQW) + 1;

    localparam logic [3:0] F_IDLE = 4'd0;
    localparam logic [3:0] F_MX   = 4'd1;
    localparam logic [3:0] F_MY   = 4'd2;
    localparam logic [3:0] F_CLS  = 4'd3;
    localparam logic [3:0] F_SQ   = 4'd4;
    localparam logic [3:0] F_PSPL = 4'd5;
    localparam logic [3:0] F_LAST = 4'd6;
    localparam logic [3:0] F_JX   = 4'd7;
    localparam logic [3:0] F_JY   = 4'd8;
    localparam logic [3:0] F_JD   = 4'd9;
    localparam logic [3:0] F_PHD  = 4'd10;
    localparam logic [3:0] F_POPN = 4'd11;
    localparam logic [3:0] F_PMRG = 4'd12;

    logic [3:0] r_state, n_state;

    logic signed [CW-1:0] r_x, r_y, r_prev_x, r_prev_y, r_first_x, r_first_y;
    logic                 r_last, r_split, r_in_scan, r_sq_join;
    logic signed [SW-1:0] r_head_sx, r_head_sy, r_open_sx, r_open_sy;
    logic [CNTW-1:0]      r_head_cnt, r_open_cnt;
    logic [LEN_W-1:0]     r_head_len, r_open_len, r_mlen;
    logic [D2W-1:0]       r_acc, r_d2;
    logic [D2W-1:0]       r_sq_n, r_sq_res, r_sq_bit;

    // Saturating add of one segment root to a path length
    function automatic logic [LEN_W-1:0] seg_add(input logic [LEN_W-1:0] a,
                                                 input logic [SQW-1:0] b);
        logic [ADDW-1:0] s;
        s = ADDW'(a) + ADDW'(b);
        return (s > ADDW'(LEN_MAX)) ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    // Shared squarer: difference picked by state
    logic signed [DXW-1:0]   m_op;
    logic signed [2*DXW-1:0] m_prod;
    logic [D2W-1:0]          m_sq;
    always_comb begin
        case (r_state)
            F_MX:    m_op = DXW'(r_x) - DXW'(r_prev_x);
            F_MY:    m_op = DXW'(r_y) - DXW'(r_prev_y);
            F_JX:    m_op = DXW'(r_x) - DXW'(r_first_x);
            default: m_op = DXW'(r_y) - DXW'(r_first_y);
        endcase
        m_prod = m_op * m_op;
        m_sq   = m_prod[D2W-1:0];
    end

    logic gap_ok;
    assign gap_ok = (CMPW'(r_d2) <= CMPW'(i_gap2));

    // Square root step, one result bit per cycle
    logic [D2W-1:0] sq_try;
    logic           sq_ge;
    assign sq_try = r_sq_res + r_sq_bit;
    assign sq_ge  = (r_sq_n >= sq_try);

    // Queue entry selection
    logic signed [SW:0]   e_sx, e_sy;
    logic [CNTW:0]        e_cnt;
    logic [LEN_W-1:0]     e_len;
    logic                 e_done;
    always_comb begin
        e_sx   = (SW+1)'(r_open_sx);
        e_sy   = (SW+1)'(r_open_sy);
        e_cnt  = (CNTW+1)'(r_open_cnt);
        e_len  = r_open_len;
        e_done = 1'b0;
        o_push = 1'b0;
        case (r_state)
            F_PSPL: o_push = !i_q_stat.full;
            F_PHD: begin
                e_sx   = (SW+1)'(r_head_sx);
                e_sy   = (SW+1)'(r_head_sy);
                e_cnt  = (CNTW+1)'(r_head_cnt);
                e_len  = r_head_len;
                o_push = !i_q_stat.full;
            end
            F_POPN: begin
                e_done = 1'b1;
                o_push = !i_q_stat.full;
            end
            F_PMRG: begin
                e_sx   = (SW+1)'(r_head_sx) + (SW+1)'(r_open_sx);
                e_sy   = (SW+1)'(r_head_sy) + (SW+1)'(r_open_sy);
                e_cnt  = (CNTW+1)'(r_head_cnt) + (CNTW+1)'(r_open_cnt);
                e_len  = seg_add(r_mlen, r_sq_res[SQW-1:0]);
                e_done = 1'b1;
                o_push = !i_q_stat.full;
            end
            default: o_push = 1'b0;
        endcase
    end
    assign o_entry = {e_sx, e_sy, e_cnt, e_len, e_done};

    assign i_pt.ready = (r_state == F_IDLE);

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (i_pt.valid) n_state = F_MX;
            F_MX:   n_state = F_MY;
            F_MY:   n_state = F_CLS;
            F_CLS: begin
                if (!r_in_scan) n_state = F_LAST;
                else if (gap_ok) n_state = F_SQ;
                else if (!r_split) n_state = F_LAST;
                else n_state = F_PSPL;
            end
            F_SQ: if (r_sq_bit == '0) n_state = r_sq_join ? F_LAST : F_PMRG;
            F_PSPL: if (!i_q_stat.full) n_state = F_LAST;
            F_LAST: n_state = r_last ? F_JX : F_IDLE;
            F_JX:   n_state = F_JY;
            F_JY:   n_state = F_JD;
            F_JD: begin
                if (r_split && gap_ok) n_state = F_SQ;
                else if (r_split) n_state = F_PHD;
                else n_state = F_POPN;
            end
            F_PHD:  if (!i_q_stat.full) n_state = F_POPN;
            F_POPN: if (!i_q_stat.full) n_state = F_IDLE;
            F_PMRG: if (!i_q_stat.full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= F_IDLE;
            r_in_scan <= 1'b0;
            r_split   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                F_IDLE: if (i_pt.valid) begin
                    r_x    <= i_pt.point_x;
                    r_y    <= i_pt.point_y;
                    r_last <= i_pt.scan_last;
                end
                F_MX: r_acc <= m_sq;
                F_MY: r_d2  <= r_acc + m_sq;
                F_CLS: begin
                    r_prev_x <= r_x;
                    r_prev_y <= r_y;
                    if (!r_in_scan || !gap_ok) begin
                        if (!r_in_scan) begin
                            r_first_x <= r_x;
                            r_first_y <= r_y;
                            r_split   <= 1'b0;
                            r_in_scan <= 1'b1;
                        end else if (!r_split) begin
                            r_head_sx  <= r_open_sx;
                            r_head_sy  <= r_open_sy;
                            r_head_cnt <= r_open_cnt;
                            r_head_len <= r_open_len;
                            r_split    <= 1'b1;
                        end
                        // a split with a held head restarts after the push
                        if (!r_in_scan || !r_split) begin
                            r_open_sx  <= SW'(r_x);
                            r_open_sy  <= SW'(r_y);
                            r_open_cnt <= CNTW'(1);
                            r_open_len <= '0;
                        end
                    end else begin
                        if (r_open_cnt < CNTW'(MAX_POINTS)) begin
                            r_open_sx  <= r_open_sx + SW'(r_x);
                            r_open_sy  <= r_open_sy + SW'(r_y);
                            r_open_cnt <= r_open_cnt + 1'b1;
                        end
                        r_sq_n    <= r_d2;
                        r_sq_res  <= '0;
                        r_sq_bit  <= D2W'(1) << (D2W - 1);
                        r_sq_join <= 1'b1;
                    end
                end
                F_SQ: begin
                    if (r_sq_bit != '0) begin
                        if (sq_ge) begin
                            r_sq_n   <= r_sq_n - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end else if (r_sq_join) begin
                        r_open_len <= seg_add(r_open_len, r_sq_res[SQW-1:0]);
                    end
                end
                F_PSPL: if (!i_q_stat.full) begin
                    r_open_sx  <= SW'(r_x);
                    r_open_sy  <= SW'(r_y);
                    r_open_cnt <= CNTW'(1);
                    r_open_len <= '0;
                end
                F_JX: r_acc <= m_sq;
                F_JY: r_d2  <= r_acc + m_sq;
                F_JD: begin
                    r_mlen    <= len_add(r_head_len, r_open_len);
                    r_sq_n    <= r_d2;
                    r_sq_res  <= '0;
                    r_sq_bit  <= D2W'(1) << (D2W - 1);
                    r_sq_join <= 1'b0;
                end
                F_POPN, F_PMRG: if (!i_q_stat.full) begin
                    r_in_scan <= 1'b0;
                    r_split   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Checks
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_q_stat.full)
        else $error("push into full queue");
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_scan && r_state != F_IDLE) |-> (r_open_cnt <= CNTW'(MAX_POINTS)))
        else $error("open count above cap");
    a_scan_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && e_done) |=> (!r_in_scan && !r_split && r_state == F_IDLE))
        else $error("scan not closed after final report");
    a_split_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_split |-> r_in_scan)
        else $error("split flag outside a scan");
endmodule

@@ design/scs_back.sv @@
// Back half: pops cluster reports, divides sums by count, drives the result.
// Depends on scs_pkg and the cluster channel interface.
module scs_back import scs_pkg::*; #(
    parameter  int MAX_POINTS  = MAX_POINTS_DEF,
    parameter  int COORD_WIDTH = COORD_WIDTH_DEF,
    localparam int CNTW = $clog2(MAX_POINTS) + 1,
    localparam int SW   = COORD_WIDTH + $clog2(MAX_POINTS),
    localparam int EW   = 2 * (SW + 1) + (CNTW + 1) + LEN_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [EW-1:0]    i_entry,
    input  t_q_stat          i_q_stat,
    output logic             o_pop,
    input  logic [LEN_W-1:0] i_min_len,
    input  logic [LEN_W-1:0] i_max_len,
    scs_cluster_if.source    o_cl
);
    localparam int ESW = SW + 1;
    localparam int QCW = CNTW + 1;
    localparam int ITW = $clog2(ESW + 1);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_OUT  = 2'd2;

    logic [1:0] r_state;

    logic signed [ESW-1:0] q_sx, q_sy;
    logic [QCW-1:0]        q_cnt;
    logic [LEN_W-1:0]      q_len;
    logic                  q_done;
    assign {q_sx, q_sy, q_cnt, q_len, q_done} = i_entry;

    logic [ESW-1:0]   r_qx, r_qy;
    logic [QCW-1:0]   r_rx, r_ry, r_cnt;
    logic             r_negx, r_negy, r_done;
    logic [LEN_W-1:0] r_len;
    logic [ITW-1:0]   r_it;
    logic             r_ov;

    // One restoring step for each coordinate
    logic [QCW:0] rsx, rsy;
    logic         gex, gey;
    assign rsx = {r_rx, r_qx[ESW-1]};
    assign rsy = {r_ry, r_qy[ESW-1]};
    assign gex = (rsx >= {1'b0, r_cnt});
    assign gey = (rsy >= {1'b0, r_cnt});

    logic [ESW-1:0]   mx, my;
    logic [CNTW-1:0]  rc;
    logic             take;
    assign mx   = r_negx ? ESW'(0) - r_qx : r_qx;
    assign my   = r_negy ? ESW'(0) - r_qy : r_qy;
    assign rc   = (r_cnt > QCW'(MAX_POINTS)) ? CNTW'(MAX_POINTS) : r_cnt[CNTW-1:0];
    assign take = (r_state == B_OUT) && (!r_ov || o_cl.ready);

    assign o_pop    = (r_state == B_IDLE) && !i_q_stat.empty;
    assign o_cl.valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (take) begin
                r_ov <= 1'b1;
            end else if (o_cl.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: if (!i_q_stat.empty) begin
                    r_negx  <= q_sx[ESW-1];
                    r_negy  <= q_sy[ESW-1];
                    r_qx    <= q_sx[ESW-1] ? ESW'(0) - q_sx : q_sx;
                    r_qy    <= q_sy[ESW-1] ? ESW'(0) - q_sy : q_sy;
                    r_rx    <= '0;
                    r_ry    <= '0;
                    r_cnt   <= q_cnt;
                    r_len   <= q_len;
                    r_done  <= q_done;
                    r_it    <= '0;
                    r_state <= B_DIV;
                end
                B_DIV: begin
                    r_rx <= gex ? QCW'(rsx - {1'b0, r_cnt}) : rsx[QCW-1:0];
                    r_ry <= gey ? QCW'(rsy - {1'b0, r_cnt}) : rsy[QCW-1:0];
                    r_qx <= {r_qx[ESW-2:0], gex};
                    r_qy <= {r_qy[ESW-2:0], gey};
                    r_it <= r_it + 1'b1;
                    if (r_it == ITW'(ESW - 1)) begin
                        r_state <= B_OUT;
                    end
                end
                B_OUT: if (take) begin
                    r_state <= B_IDLE;
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (take) begin
            o_cl.centroid_x  <= (r_cnt == '0) ? '0 : mx[COORD_WIDTH-1:0];
            o_cl.centroid_y  <= (r_cnt == '0) ? '0 : my[COORD_WIDTH-1:0];
            o_cl.path_length <= r_len;
            o_cl.point_count <= rc;
            o_cl.length_ok   <= (i_min_len <= r_len) && (r_len <= i_max_len);
            o_cl.scan_done   <= r_done;
        end
    end
endmodule

@@ dv/tb_scs_pkg.sv @@
// Testbench package: point and cluster report records for the segmenter bench.
// Depends on scs_pkg for the path length width.
`timescale 1ns / 100ps
package tb_scs_pkg;
    import scs_pkg::*;

    typedef struct {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               last;
    } t_point;

    typedef struct {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [LEN_W-1:0]   len;
        logic [12:0]        cnt;
        logic               ok;
        logic               done;
    } t_report;
endpackage

@@ dv/tb.sv @@
// Self-checking bench for scan_cluster_segmenter_core: random and directed lidar
// scans, clusters predicted in-bench and compared in order. Needs scs_pkg, scs_if.
`timescale 1ns / 100ps
module tb;
    import scs_pkg::*;
    import tb_scs_pkg::*;

    localparam int NPTS    = 4096;
    localparam int LIMIT   = 1000000;
    localparam int SCAN_N  = 420;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_GAP;
    logic [CFG_DW-1:0] i_cfg_wdata = '0;

    scs_point_if   #(.COORD_WIDTH(16)) pt_if ();
    scs_cluster_if #(.COORD_WIDTH(16), .CNT_W(13), .LEN_W(24)) cl_if ();

    scan_cluster_segmenter_core u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_pt(pt_if.sink), .o_cl(cl_if.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Segmenter state mirror
    longint gap, min_len, max_len;
    longint prv_x, prv_y, first_x, first_y;
    longint hd_sx, hd_sy, hd_cnt, hd_len;
    longint op_sx, op_sy, op_cnt, op_len;
    bit     split_seen, in_scan;

    t_point  pending_points[$];
    t_report expected_reports[$];
    int      errors = 0;
    longint  cycles = 0;
    bit      no_idle = 1'b0;

    function automatic longint floor_sqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint sat_len(longint a, longint b);
        return (a + b > LEN_MAX) ? longint'(LEN_MAX) : a + b;
    endfunction

    function automatic void push_report(longint sx, longint sy, longint cnt,
                                        longint len, bit done);
        t_report r;
        longint cx, cy;
        cx = (cnt != 0) ? sx / cnt : 0;
        cy = (cnt != 0) ? sy / cnt : 0;
        r.cx   = cx[15:0];
        r.cy   = cy[15:0];
        r.len  = len[23:0];
        r.cnt  = (cnt > NPTS) ? 13'(NPTS) : 13'(cnt);
        r.ok   = (min_len <= len) && (len <= max_len);
        r.done = done;
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    // Advance the mirror by one accepted point
    function automatic void segment_point(t_point p);
        longint x, y, d2, j2, g2, len;
        x = p.x;
        y = p.y;
        g2 = gap * gap;
        if (!in_scan) begin
            first_x = x; first_y = y;
            op_sx = x; op_sy = y; op_cnt = 1; op_len = 0;
            split_seen = 0;
            in_scan = 1;
        end else begin
            d2 = (x - prv_x) * (x - prv_x) + (y - prv_y) * (y - prv_y);
            if (d2 <= g2) begin
                if (op_cnt < NPTS) begin
                    op_sx += x; op_sy += y; op_cnt++;
                end
                op_len = sat_len(op_len, floor_sqrt(d2));
            end else begin
                if (!split_seen) begin
                    hd_sx = op_sx; hd_sy = op_sy; hd_cnt = op_cnt; hd_len = op_len;
                    split_seen = 1;
                end else begin
                    push_report(op_sx, op_sy, op_cnt, op_len, 1'b0);
                end
                op_sx = x; op_sy = y; op_cnt = 1; op_len = 0;
            end
        end
        prv_x = x;
        prv_y = y;
        if (p.last) begin
            j2 = (x - first_x) * (x - first_x) + (y - first_y) * (y - first_y);
            if (split_seen && j2 <= g2) begin
                len = sat_len(sat_len(hd_len, op_len), floor_sqrt(j2));
                push_report(hd_sx + op_sx, hd_sy + op_sy, hd_cnt + op_cnt, len, 1'b1);
            end else begin
                if (split_seen) push_report(hd_sx, hd_sy, hd_cnt, hd_len, 1'b0);
                push_report(op_sx, op_sy, op_cnt, op_len, 1'b1);
            end
            in_scan = 0;
            split_seen = 0;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // Point driver
    int src_idle = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pt_if.valid     <= 1'b0;
            pt_if.point_x   <= '0;
            pt_if.point_y   <= '0;
            pt_if.scan_last <= 1'b0;
        end else begin
            if (pt_if.valid && pt_if.ready) segment_point('{pt_if.point_x, pt_if.point_y,
                                                            pt_if.scan_last});
            if (!pt_if.valid || pt_if.ready) begin
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    pt_if.valid <= 1'b0;
                end else if (pending_points.size() > 0 &&
                             (no_idle || $urandom_range(0, 7) != 0)) begin
                    t_point p;
                    p = pending_points.pop_front();
                    pt_if.valid     <= 1'b1;
                    pt_if.point_x   <= p.x;
                    pt_if.point_y   <= p.y;
                    pt_if.scan_last <= p.last;
                end else begin
                    pt_if.valid <= 1'b0;
                    if (!no_idle && pending_points.size() > 0)
                        src_idle <= $urandom_range(0, 2);
                end
            end
        end
    end

    // Report monitor with random back-pressure bursts
    int snk_idle = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            cl_if.ready <= 1'b0;
        end else begin
            if (cl_if.valid && cl_if.ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("unexpected report", 1, 0);
                end else begin
                    t_report e;
                    e = expected_reports.pop_front();
                    if (cl_if.centroid_x !== e.cx)
                        report_mismatch("centroid_x", cl_if.centroid_x, e.cx);
                    if (cl_if.centroid_y !== e.cy)
                        report_mismatch("centroid_y", cl_if.centroid_y, e.cy);
                    if (cl_if.path_length !== e.len)
                        report_mismatch("path_length", cl_if.path_length, e.len);
                    if (cl_if.point_count !== e.cnt)
                        report_mismatch("point_count", cl_if.point_count, e.cnt);
                    if (cl_if.length_ok !== e.ok)
                        report_mismatch("length_ok", cl_if.length_ok, e.ok);
                    if (cl_if.scan_done !== e.done)
                        report_mismatch("scan_done", cl_if.scan_done, e.done);
                end
            end
            if (no_idle) begin
                cl_if.ready <= 1'b1;
            end else if (snk_idle > 0) begin
                snk_idle <= snk_idle - 1;
                cl_if.ready <= 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                snk_idle <= $urandom_range(0, 2);
                cl_if.ready <= 1'b0;
            end else begin
                cl_if.ready <= 1'b1;
            end
            if (cycles > LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // One scan: a random walk broken by occasional x jumps of at least step+50
    task automatic add_scan(int npts, int step, bit close_loop);
        t_point p;
        int x0, y0, x, y, i;
        x0 = $urandom_range(0, 20000) - 10000;
        y0 = $urandom_range(0, 20000) - 10000;
        x = x0;
        y = y0;
        for (i = 0; i < npts; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                x = x + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(step + 50, 3000));
            end else begin
                x = x + int'($urandom_range(0, 2 * step)) - step;
                y = y + int'($urandom_range(0, 2 * step)) - step;
            end
            if (i == npts - 1 && close_loop) begin
                x = x0 + int'($urandom_range(0, 20)) - 10;
                y = y0;
            end
            if (x > 32767) x = 32767;
            if (x < -32768) x = -32768;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            p.x = 16'(x); p.y = 16'(y); p.last = (i == npts - 1);
            pending_points.insert(pending_points.size(), p);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAP: gap     = val[GAP_W-1:0];
            CFG_MIN: min_len = val;
            CFG_MAX: max_len = val;
            default: ;
        endcase
    endtask

    // Wait for the block to drain, then give the front time to settle
    task automatic drain();
        while (pending_points.size() > 0 || pt_if.valid || expected_reports.size() > 0)
            @(negedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic void add_point(int x, int y, bit last);
        t_point p;
        p.x = 16'(x); p.y = 16'(y); p.last = last;
        pending_points.insert(pending_points.size(), p);
    endfunction

    initial begin
        int sent, n;
        gap = GAP_RESET; min_len = 0; max_len = LEN_MAX;
        in_scan = 0; split_seen = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-point scans, extreme coordinates, merge
        add_point(-32768, 32767, 1'b1);
        add_point(32767, -32768, 1'b1);
        add_point(0, 0, 1'b0);
        add_point(60, 80, 1'b0);
        add_point(5000, 5000, 1'b0);
        add_point(5050, 5000, 1'b0);
        add_point(-5000, 0, 1'b0);
        add_point(10, 10, 1'b1);
        add_point(100, 100, 1'b0);
        add_point(-100, -100, 1'b0);
        add_point(3000, 3000, 1'b1);
        drain();

        // Widest gap: every hop lies exactly on the gap and joins
        write_reg(CFG_GAP, 24'h7FFF);
        write_reg(CFG_MIN, 24'd1000);
        write_reg(CFG_MAX, 24'd50000);
        for (int i = 0; i < 12; i++)
            add_point((i % 2) ? 16383 : -16384, 0, i == 11);
        drain();

        // Zero gap: only repeated points join
        write_reg(CFG_GAP, 24'd0);
        write_reg(CFG_MIN, 24'hFFFFFF);
        write_reg(CFG_MAX, 24'd0);
        add_point(7, 7, 1'b0);
        add_point(7, 7, 1'b0);
        add_point(8, 7, 1'b0);
        add_point(7, 7, 1'b1);
        drain();

        // Random scans under several settings
        sent = 0;
        for (int phase = 0; phase < 4; phase++) begin
            write_reg(CFG_GAP, CFG_DW'($urandom_range(20, 400)));
            write_reg(CFG_MIN, CFG_DW'($urandom_range(0, 300)));
            write_reg(CFG_MAX, CFG_DW'($urandom_range(200, 3000)));
            while (sent < (phase + 1) * SCAN_N / 4) begin
                n = $urandom_range(1, 12);
                add_scan(n, 80, $urandom_range(0, 1));
                sent += n;
                if (phase == 3 && sent > SCAN_N * 7 / 8) no_idle = 1'b1;
            end
            drain();
        end

        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_reports.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
